>>> sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared constants and types for the sorted table
// command and status codes, table sizing and the per-cell control group
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_OUT_W = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    // broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

>>> sv/sorted_table_insert_search_delete.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_search_delete: ascending table with insert/search/delete
// a row of compare-and-shift cells kept in sorted order, plus an entry count
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat carries cmd (insert, search, delete) and a
//   signed 32-bit key_value, taken when in_valid is high and in_stall low
//   output channel: one beat per command with status and entry_count
//   all cells compare against the key at once; the edge that takes a command
//   also shifts the row and loads the output register, so the result beat
//   shows in the cycle after the command beat
//   throughput: one command per cycle while the output is not stalled, set
//   by the single compare-and-shift pass through the cell row
//   a pending result is held in the output register; while out_stall holds
//   it there, in_stall is raised and no new command is taken
//   reset clears the count and the output valid; entry storage is not
//   cleared, slots at or above the count are simply ignored
//   insert into a full table and unknown commands leave the table unchanged
// ----------------------------------------------------------------------------
module sorted_table_insert_search_delete
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [sts_pkg::CMD_W-1:0]               cmd,
    input  logic signed [sts_pkg::DATA_W-1:0]       key_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [sts_pkg::STATUS_W-1:0]            status,
    output logic [sts_pkg::COUNT_OUT_W-1:0]         entry_count
);

    localparam int CAP = sts_pkg::CAPACITY;
    localparam logic [sts_pkg::CNT_W-1:0] CAP_CNT = sts_pkg::CNT_W'(CAP);

    logic [sts_pkg::CNT_W-1:0]          count_reg;
    logic [sts_pkg::CNT_W-1:0]          count_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [sts_pkg::STATUS_W-1:0]       status_reg;
    logic [sts_pkg::STATUS_W-1:0]       status_next;
    logic [sts_pkg::COUNT_OUT_W-1:0]    entry_count_reg;

    logic                               accept;
    logic                               is_empty;
    logic                               is_full;
    logic                               found;
    sts_pkg::cell_ctrl_t                ctrl;

    // per-cell signals along the row
    logic signed [sts_pkg::DATA_W-1:0]  cell_entry [CAP];
    logic [CAP-1:0]                     cell_lt;
    logic [CAP-1:0]                     cell_hit;
    logic [CAP-1:0]                     cell_occ;

    // the output register is the only buffer: stall upstream while it is held
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg >= CAP_CNT);
    // at most one cell sits at the lower-bound boundary
    assign found    = |cell_hit;

    assign ctrl.ins = accept && (cmd == sts_pkg::CMD_INSERT) && !is_full;
    assign ctrl.del = accept && (cmd == sts_pkg::CMD_DELETE) && found;

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++)
        begin : g_cell
            logic                              left_lt_w;
            logic signed [sts_pkg::DATA_W-1:0] left_w;
            logic signed [sts_pkg::DATA_W-1:0] right_w;

            // a slot is live when it sits below the count
            assign cell_occ[gi] = (sts_pkg::CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_lt_w = 1'b1;
                assign left_w    = key_value;
            end
            else
            begin : g_body
                assign left_lt_w = cell_lt[gi-1];
                assign left_w    = cell_entry[gi-1];
            end

            if (gi == CAP - 1)
            begin : g_tail
                // shifted into a slot that falls past the count, never read
                assign right_w = '0;
            end
            else
            begin : g_mid
                assign right_w = cell_entry[gi+1];
            end

            sts_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .key         (key_value),
                .occupied    (cell_occ[gi]),
                .left_lt     (left_lt_w),
                .left_entry  (left_w),
                .right_entry (right_w),
                .entry       (cell_entry[gi]),
                .lt          (cell_lt[gi]),
                .hit         (cell_hit[gi])
            );
        end
    endgenerate

    // status and count for the command being taken
    always_comb
    begin
        count_next  = count_reg;
        status_next = sts_pkg::ST_MISSING;
        case (cmd)
            sts_pkg::CMD_INSERT:
            begin
                if (is_full)
                begin
                    status_next = sts_pkg::ST_FULL;
                end
                else
                begin
                    status_next = sts_pkg::ST_INSERTED;
                    count_next  = count_reg + sts_pkg::CNT_W'(1);
                end
            end
            sts_pkg::CMD_SEARCH:
            begin
                if (is_empty)
                begin
                    status_next = sts_pkg::ST_EMPTY;
                end
                else if (found)
                begin
                    status_next = sts_pkg::ST_FOUND;
                end
            end
            sts_pkg::CMD_DELETE:
            begin
                if (is_empty)
                begin
                    status_next = sts_pkg::ST_EMPTY;
                end
                else if (found)
                begin
                    status_next = sts_pkg::ST_DELETED;
                    count_next  = count_reg - sts_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                status_next = sts_pkg::ST_MISSING;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload, loaded with each command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            entry_count_reg <= sts_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_hit))
        else $error("more than one cell at the lower bound");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted command produced no result beat");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == sts_pkg::ST_FULL)) |-> (count_reg == CAP_CNT))
        else $error("full reported with room left");

endmodule

>>> sv/sts_cell.sv
// ----------------------------------------------------------------------------
// sts_cell: one slot of the sorted table
// holds one entry, compares it against the key and shifts with its neighbors
// ----------------------------------------------------------------------------
module sts_cell
(
    input  logic                                clk,
    input  sts_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [sts_pkg::DATA_W-1:0]   key,
    input  logic                                occupied,
    input  logic                                left_lt,
    input  logic signed [sts_pkg::DATA_W-1:0]   left_entry,
    input  logic signed [sts_pkg::DATA_W-1:0]   right_entry,
    output logic signed [sts_pkg::DATA_W-1:0]   entry,
    output logic                                lt,
    output logic                                hit
);

    logic signed [sts_pkg::DATA_W-1:0] entry_reg;
    logic signed [sts_pkg::DATA_W-1:0] entry_next;
    logic                              at_pos;

    assign lt     = occupied && (entry_reg < key);
    // first slot holding a value >= key (or first free slot)
    assign at_pos = !lt && left_lt;
    assign hit    = at_pos && occupied && (entry_reg == key);
    assign entry  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && !lt)
        begin
            entry_next = at_pos ? key : left_entry;
        end
        else if (ctrl.del && !lt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> tb/sv/sorted_table_insert_search_delete_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_search_delete_test: self-checking bench for the table
// drives insert, search and delete beats with random gaps and output stalls,
// predicts each status and entry count from a private copy of the table and
// compares every result beat against the oldest prediction
// ----------------------------------------------------------------------------
module sorted_table_insert_search_delete_test;

    // selector value the block must treat as a no-op
    localparam logic [sts_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // generous bound: ~1700 beats with worst-case gaps and stalls, several times over
    localparam int CYCLE_LIMIT = 400000;

    // traffic mix of one random segment
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } traffic_mix_t;

    // one predicted result beat
    typedef struct packed {
        logic [sts_pkg::STATUS_W-1:0]    status;
        logic [sts_pkg::COUNT_OUT_W-1:0] count;
    } table_reply_t;

    // ------------------------------------------------------------------------
    // scoreboard: private sorted table plus the queue of replies still due
    // ------------------------------------------------------------------------
    class sorted_table_scoreboard;
        logic signed [sts_pkg::DATA_W-1:0] held[$];
        table_reply_t                      replies_due[$];
        int                                mismatches;

        function new();
            mismatches = 0;
        endfunction

        // first slot whose value is >= key, or the table size
        function int first_not_below(logic signed [sts_pkg::DATA_W-1:0] key);
            int pos;
            pos = 0;
            while (pos < held.size() && held[pos] < key)
                pos++;
            return pos;
        endfunction

        // update the table for one command and return its status
        function logic [sts_pkg::STATUS_W-1:0] apply_command(
            logic [sts_pkg::CMD_W-1:0] op,
            logic signed [sts_pkg::DATA_W-1:0] key);
            int pos;
            pos = first_not_below(key);
            case (op)
                sts_pkg::CMD_INSERT:
                begin
                    if (held.size() >= sts_pkg::CAPACITY)
                        return sts_pkg::ST_FULL;
                    held.insert(pos, key);
                    return sts_pkg::ST_INSERTED;
                end
                sts_pkg::CMD_SEARCH:
                begin
                    if (held.size() == 0)
                        return sts_pkg::ST_EMPTY;
                    if (pos < held.size() && held[pos] == key)
                        return sts_pkg::ST_FOUND;
                    return sts_pkg::ST_MISSING;
                end
                sts_pkg::CMD_DELETE:
                begin
                    if (held.size() == 0)
                        return sts_pkg::ST_EMPTY;
                    if (pos >= held.size() || held[pos] != key)
                        return sts_pkg::ST_MISSING;
                    held.delete(pos);
                    return sts_pkg::ST_DELETED;
                end
                default:
                    return sts_pkg::ST_MISSING;
            endcase
        endfunction

        function void note_command(logic [sts_pkg::CMD_W-1:0] op,
                                   logic signed [sts_pkg::DATA_W-1:0] key);
            table_reply_t reply;
            reply.status = apply_command(op, key);
            reply.count  = sts_pkg::COUNT_OUT_W'(held.size());
            replies_due.push_back(reply);
        endfunction

        function void check_reply(logic [sts_pkg::STATUS_W-1:0] got_status,
                                  logic [sts_pkg::COUNT_OUT_W-1:0] got_count);
            table_reply_t want;
            if (replies_due.size() == 0)
            begin
                $error("result beat with no command waiting: status %0d entry_count %0d",
                       got_status, got_count);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (got_status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                mismatches++;
            end
            if (got_count !== want.count)
            begin
                $error("entry_count: expected %0d, got %0d", want.count, got_count);
                mismatches++;
            end
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [sts_pkg::CMD_W-1:0]           cmd;
    logic signed [sts_pkg::DATA_W-1:0]   key_value;
    logic                                out_valid;
    logic                                out_stall;
    logic [sts_pkg::STATUS_W-1:0]        status;
    logic [sts_pkg::COUNT_OUT_W-1:0]     entry_count;

    sorted_table_scoreboard       board;
    // set for whole segments: neither side idles then
    bit                           no_idle = 1'b0;
    int                           cycle_count = 0;

    sorted_table_insert_search_delete dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .key_value   (key_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_count (entry_count)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // monitor: the result beat is checked before the command beat of the same
    // edge is noted, so a spurious result never consumes a fresh prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_reply(status, entry_count);
            if (in_valid && !in_stall)
                board.note_command(cmd, key_value);
        end
    end

    // watchdog on total run length
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: per result beat, stall for a random number of cycles, then
    // take the beat; stalls also land on cycles where nothing is pending
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = no_idle ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // ------------------------------------------------------------------------
    // sender: entered and left at a falling edge; valid stays high across
    // back-to-back beats and only drops when a gap is drawn
    // ------------------------------------------------------------------------
    task automatic send_command(input logic [sts_pkg::CMD_W-1:0] op,
                                input logic signed [sts_pkg::DATA_W-1:0] key);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        key_value <= key;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // hold off until every predicted result has arrived
    task automatic drain_replies();
        in_valid <= 1'b0;
        while (board.replies_due.size() != 0)
            @(negedge clk);
    endtask

    // key source: mostly held values and a narrow band so hits and duplicates
    // are common, plus values near both extremes and fully random words
    function automatic logic signed [sts_pkg::DATA_W-1:0] pick_key();
        int r;
        logic signed [sts_pkg::DATA_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 40 && board.held.size() > 0)
            k = board.held[$urandom_range(0, board.held.size() - 1)];
        else if (r < 70)
            k = sts_pkg::DATA_W'($urandom_range(0, 32)) - sts_pkg::DATA_W'(16);
        else if (r < 80)
            k = {1'b0, {(sts_pkg::DATA_W-1){1'b1}}}
                - sts_pkg::DATA_W'($urandom_range(0, 2));
        else if (r < 88)
            k = {1'b1, {(sts_pkg::DATA_W-1){1'b0}}}
                + sts_pkg::DATA_W'($urandom_range(0, 2));
        else
            k = $urandom;
        return k;
    endfunction

    function automatic logic [sts_pkg::CMD_W-1:0] pick_command(traffic_mix_t mix);
        int r;
        int ins_cut;
        int srch_cut;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin ins_cut = 65; srch_cut = 80; end
            MIX_DRAIN: begin ins_cut = 22; srch_cut = 37; end
            default:   begin ins_cut = 40; srch_cut = 65; end
        endcase
        if (r < ins_cut)
            return sts_pkg::CMD_INSERT;
        if (r < srch_cut)
            return sts_pkg::CMD_SEARCH;
        if (r < 97)
            return sts_pkg::CMD_DELETE;
        return CMD_UNUSED;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        traffic_mix_t mix;
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = sts_pkg::CMD_INSERT;
        key_value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table: search, delete and the unused selector
        send_command(sts_pkg::CMD_SEARCH, 32'sd7);
        send_command(sts_pkg::CMD_DELETE, 32'sd7);
        send_command(CMD_UNUSED, 32'sd7);
        // first insert into an empty table is the maximum, then the minimum and a duplicate
        send_command(sts_pkg::CMD_INSERT, {1'b0, {(sts_pkg::DATA_W-1){1'b1}}});
        send_command(sts_pkg::CMD_INSERT, {1'b1, {(sts_pkg::DATA_W-1){1'b0}}});
        send_command(sts_pkg::CMD_INSERT, 32'sd0);
        send_command(sts_pkg::CMD_INSERT, 32'sd0);
        send_command(sts_pkg::CMD_SEARCH, 32'sd0);
        send_command(sts_pkg::CMD_SEARCH, 32'sd5);
        // smallest entry removed like any other, absent value left alone
        send_command(sts_pkg::CMD_DELETE, {1'b1, {(sts_pkg::DATA_W-1){1'b0}}});
        send_command(sts_pkg::CMD_DELETE, 32'sd9);
        send_command(CMD_UNUSED, 32'sd0);
        // only the first of two equal entries goes
        send_command(sts_pkg::CMD_DELETE, 32'sd0);
        send_command(sts_pkg::CMD_SEARCH, 32'sd0);
        // fill to capacity, then an insert that must be refused
        while (board.held.size() < sts_pkg::CAPACITY)
            send_command(sts_pkg::CMD_INSERT, -32'sd1);
        send_command(sts_pkg::CMD_INSERT, 32'sd3);
        send_command(sts_pkg::CMD_SEARCH, {1'b0, {(sts_pkg::DATA_W-1){1'b1}}});

        // random segments swinging the table between full and empty
        for (int seg = 0; seg < 16; seg++)
        begin
            mix     = traffic_mix_t'(seg % 3);
            no_idle = (seg % 4 == 3);
            for (int n = 0; n < 100; n++)
                send_command(pick_command(mix), pick_key());
            // one hold-off with the pipe fully emptied
            if (seg == 7)
                drain_replies();
        end
        no_idle = 1'b0;

        in_valid <= 1'b0;
        while (board.replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (board.mismatches == 0 && board.replies_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/sts_pkg.sv
sv/sts_cell.sv
sv/sorted_table_insert_search_delete.sv
tb/sv/sorted_table_insert_search_delete_test.sv
